>>> hdl/tgad_pkg.sv
// Shared types and codes for the TGA stream decoder.
package tgad_pkg;

    localparam int unsigned OUT_DATA_W = 72;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Rejection causes, in the order the checks are made.
    localparam logic [1:0] CAUSE_COLOR_MAP = 2'd0;
    localparam logic [1:0] CAUSE_IMG_TYPE  = 2'd1;
    localparam logic [1:0] CAUSE_DEPTH     = 2'd2;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  reject_cause;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
    } t_result;

endpackage

>>> hdl/tgad_in_stage.sv
// Input register stage of the TGA stream decoder.
module tgad_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tgad_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output tgad_pkg::t_in_item o_item
);

    logic               r_valid;
    tgad_pkg::t_in_item r_item;

    // The register can load when empty or when its content moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hdl/tgad_core.sv
// Header parser, ID skipper and pixel assembler of the TGA stream decoder.
module tgad_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  tgad_pkg::t_in_item i_item,
    output logic               o_has_result,
    output tgad_pkg::t_result  o_result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    // Byte offsets of the header fields.
    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_LAST     = 5'd17;

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] TYPE_GRAY      = 8'd3;
    localparam logic [7:0] DEPTH_8        = 8'd8;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;

    logic [1:0]  r_phase,       n_phase;
    logic [4:0]  r_hdr_idx,     n_hdr_idx;
    logic [7:0]  r_id_left,     n_id_left;
    logic [7:0]  r_map_type,    n_map_type;
    logic [7:0]  r_img_type,    n_img_type;
    logic [15:0] r_width,       n_width;
    logic [15:0] r_height,      n_height;
    logic [7:0]  r_depth,       n_depth;
    logic [31:0] r_pix_left,    n_pix_left;
    logic [1:0]  r_byte_in_pix, n_byte_in_pix;
    logic [23:0] r_partial,     n_partial;

    logic [1:0]  b_phase;
    logic [4:0]  b_hdr_idx;
    logic [7:0]  b_id_left;
    logic [7:0]  b_map_type;
    logic [7:0]  b_img_type;
    logic [15:0] b_width;
    logic [15:0] b_height;
    logic [7:0]  b_depth;
    logic [31:0] b_pix_left;
    logic [1:0]  b_byte_in_pix;
    logic [23:0] b_partial;

    logic        bad_map;
    logic        bad_type;
    logic        bad_depth;
    logic [1:0]  need;
    logic [7:0]  byte_in;

    assign byte_in = i_item.file_byte;

    // A start flag restarts the parser before this byte is looked at.
    always_comb begin
        if (i_item.file_start) begin
            b_phase       = PH_HEADER;
            b_hdr_idx     = '0;
            b_id_left     = '0;
            b_map_type    = '0;
            b_img_type    = '0;
            b_width       = '0;
            b_height      = '0;
            b_depth       = '0;
            b_pix_left    = '0;
            b_byte_in_pix = '0;
            b_partial     = '0;
        end else begin
            b_phase       = r_phase;
            b_hdr_idx     = r_hdr_idx;
            b_id_left     = r_id_left;
            b_map_type    = r_map_type;
            b_img_type    = r_img_type;
            b_width       = r_width;
            b_height      = r_height;
            b_depth       = r_depth;
            b_pix_left    = r_pix_left;
            b_byte_in_pix = r_byte_in_pix;
            b_partial     = r_partial;
        end
    end

    assign bad_map   = (b_map_type != 8'd0);
    assign bad_type  = (b_img_type != TYPE_TRUECOLOR) && (b_img_type != TYPE_GRAY);
    assign bad_depth = (b_depth != DEPTH_8) && (b_depth != DEPTH_24) &&
                       (b_depth != DEPTH_32);
    assign need      = (b_depth == DEPTH_32) ? 2'd3 : 2'd2;

    always_comb begin
        n_phase       = b_phase;
        n_hdr_idx     = b_hdr_idx;
        n_id_left     = b_id_left;
        n_map_type    = b_map_type;
        n_img_type    = b_img_type;
        n_width       = b_width;
        n_height      = b_height;
        n_depth       = b_depth;
        n_pix_left    = b_pix_left;
        n_byte_in_pix = b_byte_in_pix;
        n_partial     = b_partial;
        o_has_result  = 1'b0;
        o_result      = '0;

        unique case (b_phase)
            PH_HEADER: begin
                unique case (b_hdr_idx)
                    HDR_ID_LEN:    n_id_left        = byte_in;
                    HDR_MAP_TYPE:  n_map_type       = byte_in;
                    HDR_IMG_TYPE:  n_img_type       = byte_in;
                    HDR_WIDTH_LO:  n_width[7:0]     = byte_in;
                    HDR_WIDTH_HI:  n_width[15:8]    = byte_in;
                    HDR_HEIGHT_LO: n_height[7:0]    = byte_in;
                    HDR_HEIGHT_HI: n_height[15:8]   = byte_in;
                    HDR_DEPTH:     n_depth          = byte_in;
                    default: ;
                endcase
                if (b_hdr_idx == HDR_LAST) begin
                    // Last header byte: validate and announce the image.
                    n_hdr_idx    = '0;
                    o_has_result = 1'b1;
                    if (bad_map || bad_type || bad_depth) begin
                        o_result.kind = tgad_pkg::KIND_REJECT;
                        priority if (bad_map) begin
                            o_result.reject_cause = tgad_pkg::CAUSE_COLOR_MAP;
                        end else if (bad_type) begin
                            o_result.reject_cause = tgad_pkg::CAUSE_IMG_TYPE;
                        end else begin
                            o_result.reject_cause = tgad_pkg::CAUSE_DEPTH;
                        end
                        n_phase = PH_IDLE;
                    end else begin
                        o_result.kind         = tgad_pkg::KIND_HEADER;
                        o_result.image_width  = b_width;
                        o_result.image_height = b_height;
                        n_pix_left    = 32'(b_width) * 32'(b_height);
                        n_byte_in_pix = '0;
                        n_partial     = '0;
                        if (b_id_left != 8'd0) begin
                            n_phase = PH_SKIP;
                        end else if (b_width != 16'd0 && b_height != 16'd0) begin
                            n_phase = PH_PIXELS;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end else begin
                    n_hdr_idx = b_hdr_idx + 5'd1;
                end
            end
            PH_SKIP: begin
                n_id_left = b_id_left - 8'd1;
                if (b_id_left == 8'd1) begin
                    n_phase = (b_pix_left != 32'd0) ? PH_PIXELS : PH_IDLE;
                end
            end
            PH_PIXELS: begin
                if (b_depth != DEPTH_8 && b_byte_in_pix < need) begin
                    // Collect the leading bytes of a multi-byte pixel.
                    unique case (b_byte_in_pix)
                        2'd0:    n_partial[7:0]   = byte_in;
                        2'd1:    n_partial[15:8]  = byte_in;
                        default: n_partial[23:16] = byte_in;
                    endcase
                    n_byte_in_pix = b_byte_in_pix + 2'd1;
                end else begin
                    o_has_result  = 1'b1;
                    o_result.kind = tgad_pkg::KIND_PIXEL;
                    if (b_depth == DEPTH_8) begin
                        o_result.red   = byte_in;
                        o_result.green = byte_in;
                        o_result.blue  = byte_in;
                        o_result.alpha = 8'hFF;
                    end else if (b_depth == DEPTH_32) begin
                        o_result.blue  = b_partial[7:0];
                        o_result.green = b_partial[15:8];
                        o_result.red   = b_partial[23:16];
                        o_result.alpha = byte_in;
                    end else begin
                        o_result.blue  = b_partial[7:0];
                        o_result.green = b_partial[15:8];
                        o_result.red   = byte_in;
                        o_result.alpha = 8'hFF;
                    end
                    n_byte_in_pix       = '0;
                    n_partial           = '0;
                    n_pix_left          = b_pix_left - 32'd1;
                    o_result.last_pixel = (b_pix_left == 32'd1);
                    if (b_pix_left == 32'd1) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_hdr_idx     <= '0;
            r_id_left     <= '0;
            r_map_type    <= '0;
            r_img_type    <= '0;
            r_width       <= '0;
            r_height      <= '0;
            r_depth       <= '0;
            r_pix_left    <= '0;
            r_byte_in_pix <= '0;
            r_partial     <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_hdr_idx     <= n_hdr_idx;
            r_id_left     <= n_id_left;
            r_map_type    <= n_map_type;
            r_img_type    <= n_img_type;
            r_width       <= n_width;
            r_height      <= n_height;
            r_depth       <= n_depth;
            r_pix_left    <= n_pix_left;
            r_byte_in_pix <= n_byte_in_pix;
            r_partial     <= n_partial;
        end
    end

endmodule

>>> hdl/tgad_out_stage.sv
// Result register stage of the TGA stream decoder.
module tgad_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_has_result,
    input  tgad_pkg::t_result i_result,
    output logic              o_advance,
    output logic              o_valid,
    input  logic              i_ready,
    output tgad_pkg::t_result o_result
);

    logic              r_valid;
    tgad_pkg::t_result r_result;

    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_in_valid && i_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> hdl/tga_uncompressed_decoder.sv
// Top level of the streaming decoder for uncompressed TGA image files.
//
// The slave channel takes the file one byte per request on tdata, with tuser
// high on the first byte of a new file; that byte restarts the parser and
// drops any file in progress. The 18-byte header is parsed, the image-ID bytes
// are skipped, and one header request (width, height) or one reject request
// (with its cause) is sent on the master channel when header byte 17 arrives.
// An accepted file then gives one RGBA pixel request per completed source
// pixel, with tlast on the final pixel. Bytes after the last pixel or after a
// rejection are dropped until the next start byte.
// Throughput is one byte per clock while the receiver does not stall. A byte
// waits in the input register; its request, if any, then goes to the result
// register, which drives tvalid. The single 16x16 multiply for the pixel
// count sits between the width/height registers and the pixel counter. When
// the receiver stalls, the result register holds, no byte moves on, and the
// input register takes one more byte only if it is empty, then tready drops.
// Synchronous reset clears both stages and returns the parser to header
// byte 0, so a stream without a start flag is parsed from its first byte.
module tga_uncompressed_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] file_byte
    input  logic        i_s_axis_tuser,   // [0] file_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] reject_cause, [17:2] image_width, [33:18] image_height,
    // [41:34] red, [49:42] green, [57:50] blue, [65:58] alpha, [71:66] zero
    output logic [tgad_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last_pixel
);

    tgad_pkg::t_in_item in_item;
    tgad_pkg::t_in_item stage_item;
    tgad_pkg::t_result  core_result;
    tgad_pkg::t_result  out_result;
    logic               stage_valid;
    logic               advance;
    logic               core_has_result;

    assign in_item.file_byte  = i_s_axis_tdata;
    assign in_item.file_start = i_s_axis_tuser;

    tgad_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // The parser state moves only when the byte in the input register moves on.
    tgad_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (stage_valid && advance),
        .i_item       (stage_item),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    tgad_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (stage_valid),
        .i_has_result (core_has_result),
        .i_result     (core_result),
        .o_advance    (advance),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_result     (out_result)
    );

    assign o_m_axis_tdata = {6'd0, out_result.alpha, out_result.blue, out_result.green,
                             out_result.red, out_result.image_height,
                             out_result.image_width, out_result.reject_cause};
    assign o_m_axis_tuser = out_result.kind;
    assign o_m_axis_tlast = out_result.last_pixel;

`ifndef SYNTHESIS
    // Only pixel requests may mark the end of an image.
    a_last_only_on_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser == tgad_pkg::KIND_PIXEL)
        else $error("tlast set on a non-pixel request");

    // A reject request carries only its cause.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == tgad_pkg::KIND_REJECT
        |-> o_m_axis_tdata[tgad_pkg::OUT_DATA_W-1:2] == '0)
        else $error("reject request carries header or pixel data");

    // Reset empties the result register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

>>> tb/tga_uncompressed_decoder_tb.sv
// Self-checking testbench for the TGA stream decoder, with its own byte-level decode predictor.
`timescale 1ns / 1ps

module tga_uncompressed_decoder_tb;

    // Header codes that the decoder accepts.
    localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
    localparam logic [7:0] IMG_GRAY      = 8'd3;
    localparam logic [7:0] DEPTH_GRAY    = 8'd8;
    localparam logic [7:0] DEPTH_BGR     = 8'd24;
    localparam logic [7:0] DEPTH_BGRA    = 8'd32;
    localparam int HEADER_LEN    = 18;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_PRINTED   = 40;

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_SKIP_ID,
        DEC_PIXELS,
        DEC_DONE
    } t_dec_phase;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [7:0]            s_tdata   = 8'd0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [tgad_pkg::OUT_DATA_W-1:0] m_tdata;
    wire [1:0]             m_tuser;
    wire                   m_tlast;

    tga_uncompressed_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Idle rates in percent and the receiver hold-off request.
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 77;
    int          hold_request  = 0;
    int          hold_left     = 0;

    // Decode predictor state.
    t_dec_phase  dec_phase = DEC_HEADER;
    logic [4:0]  hdr_pos   = '0;
    logic [7:0]  id_left   = '0;
    logic [7:0]  map_kind  = '0;
    logic [7:0]  img_type  = '0;
    logic [15:0] img_w     = '0;
    logic [15:0] img_h     = '0;
    logic [7:0]  px_depth  = '0;
    logic [31:0] px_left   = '0;
    logic [1:0]  px_byte   = '0;
    logic [23:0] px_acc    = '0;

    tgad_pkg::t_result expected_results[$];
    tgad_pkg::t_result got_res;
    tgad_pkg::t_result exp_res;

    int unsigned bytes_consumed = 0;
    int unsigned files_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned header_results = 0;
    int unsigned pixel_results  = 0;
    int unsigned reject_results = 0;
    int unsigned mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
        end
    endtask

    // Advances the predictor by one accepted byte and queues any result it causes.
    task automatic decode_byte(input logic [7:0] b, input logic st);
        tgad_pkg::t_result res;
        logic [1:0] need;
        logic       emit;
        res  = '0;
        emit = 1'b0;
        if (st) begin
            dec_phase = DEC_HEADER;
            hdr_pos   = '0;
            id_left   = '0;
            map_kind  = '0;
            img_type  = '0;
            img_w     = '0;
            img_h     = '0;
            px_depth  = '0;
            px_left   = '0;
            px_byte   = '0;
            px_acc    = '0;
        end
        if (dec_phase != DEC_DONE) begin
            bytes_consumed++;
        end
        case (dec_phase)
            DEC_HEADER: begin
                case (hdr_pos)
                    5'd0:  id_left = b;
                    5'd1:  map_kind = b;
                    5'd2:  img_type = b;
                    5'd12: img_w[7:0] = b;
                    5'd13: img_w[15:8] = b;
                    5'd14: img_h[7:0] = b;
                    5'd15: img_h[15:8] = b;
                    5'd16: px_depth = b;
                    default: ;
                endcase
                hdr_pos = hdr_pos + 5'd1;
                if (hdr_pos == HEADER_LEN) begin
                    hdr_pos = '0;
                    emit    = 1'b1;
                    // Checks run in a fixed order; the first one that fails names the cause.
                    if (map_kind != 8'd0) begin
                        res.kind         = tgad_pkg::KIND_REJECT;
                        res.reject_cause = tgad_pkg::CAUSE_COLOR_MAP;
                        dec_phase        = DEC_DONE;
                    end else if (img_type != IMG_TRUECOLOR && img_type != IMG_GRAY) begin
                        res.kind         = tgad_pkg::KIND_REJECT;
                        res.reject_cause = tgad_pkg::CAUSE_IMG_TYPE;
                        dec_phase        = DEC_DONE;
                    end else if (px_depth != DEPTH_GRAY && px_depth != DEPTH_BGR &&
                                 px_depth != DEPTH_BGRA) begin
                        res.kind         = tgad_pkg::KIND_REJECT;
                        res.reject_cause = tgad_pkg::CAUSE_DEPTH;
                        dec_phase        = DEC_DONE;
                    end else begin
                        px_left          = {16'd0, img_w} * {16'd0, img_h};
                        res.kind         = tgad_pkg::KIND_HEADER;
                        res.image_width  = img_w;
                        res.image_height = img_h;
                        px_byte          = '0;
                        px_acc           = '0;
                        if (id_left != 8'd0) begin
                            dec_phase = DEC_SKIP_ID;
                        end else if (px_left != 32'd0) begin
                            dec_phase = DEC_PIXELS;
                        end else begin
                            dec_phase = DEC_DONE;
                        end
                    end
                end
            end
            DEC_SKIP_ID: begin
                id_left = id_left - 8'd1;
                if (id_left == 8'd0) begin
                    dec_phase = (px_left != 32'd0) ? DEC_PIXELS : DEC_DONE;
                end
            end
            DEC_PIXELS: begin
                need = (px_depth == DEPTH_BGRA) ? 2'd3 : 2'd2;
                if (px_depth == DEPTH_GRAY) begin
                    res.red   = b;
                    res.green = b;
                    res.blue  = b;
                    res.alpha = 8'hFF;
                    emit      = 1'b1;
                end else if (px_byte < need) begin
                    px_acc[8*px_byte +: 8] = b;
                    px_byte = px_byte + 2'd1;
                end else begin
                    // Source order is blue, green, red, then alpha for 32-bit pixels.
                    res.blue  = px_acc[7:0];
                    res.green = px_acc[15:8];
                    if (px_depth == DEPTH_BGRA) begin
                        res.red   = px_acc[23:16];
                        res.alpha = b;
                    end else begin
                        res.red   = b;
                        res.alpha = 8'hFF;
                    end
                    px_byte = '0;
                    px_acc  = '0;
                    emit    = 1'b1;
                end
                if (emit) begin
                    px_left        = px_left - 32'd1;
                    res.kind       = tgad_pkg::KIND_PIXEL;
                    res.last_pixel = (px_left == 32'd0);
                    if (px_left == 32'd0) begin
                        dec_phase = DEC_DONE;
                    end
                end
            end
            default: ;
        endcase
        if (emit) begin
            expected_results.push_back(res);
        end
    endtask

    // Offers one byte, waits for its handshake, then feeds the predictor.
    // Valid stays high after acceptance so that back-to-back bytes need no idle gap.
    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        decode_byte(b, st);
    endtask

    task automatic send_random_bytes(input int count);
        for (int i = 0; i < count; i++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Sends the first nbytes of a header; bytes the decoder does not use are random.
    task automatic send_header(input logic st0, input logic [7:0] id_len,
                               input logic [7:0] map, input logic [7:0] itype,
                               input logic [15:0] w, input logic [15:0] h,
                               input logic [7:0] depth, input int nbytes);
        logic [7:0] hdr [HEADER_LEN];
        for (int i = 0; i < HEADER_LEN; i++) begin
            hdr[i] = 8'($urandom_range(0, 255));
        end
        hdr[0]  = id_len;
        hdr[1]  = map;
        hdr[2]  = itype;
        hdr[12] = w[7:0];
        hdr[13] = w[15:8];
        hdr[14] = h[7:0];
        hdr[15] = h[15:8];
        hdr[16] = depth;
        files_sent++;
        for (int i = 0; i < nbytes; i++) begin
            send_byte(hdr[i], (i == 0) ? st0 : 1'b0);
        end
    endtask

    task automatic send_file(input logic st0, input logic [7:0] id_len,
                             input logic [7:0] map, input logic [7:0] itype,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] depth, input int data_bytes);
        send_header(st0, id_len, map, itype, w, h, depth, HEADER_LEN);
        send_random_bytes(int'(id_len));
        send_random_bytes(data_bytes);
    endtask

    function automatic int image_bytes(input logic [15:0] w, input logic [15:0] h,
                                       input logic [7:0] depth);
        return int'(w) * int'(h) * (int'(depth) / 8);
    endfunction

    // Stops offering and waits until every predicted result has been seen.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checker: every accepted request is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            got_res.kind         = m_tuser;
            got_res.reject_cause = m_tdata[1:0];
            got_res.image_width  = m_tdata[17:2];
            got_res.image_height = m_tdata[33:18];
            got_res.red          = m_tdata[41:34];
            got_res.green        = m_tdata[49:42];
            got_res.blue         = m_tdata[57:50];
            got_res.alpha        = m_tdata[65:58];
            got_res.last_pixel   = m_tlast;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected request of kind %0d", got_res.kind));
            end else begin
                exp_res = expected_results.pop_front();
                if (got_res.kind !== exp_res.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              got_res.kind, exp_res.kind));
                if (got_res.reject_cause !== exp_res.reject_cause)
                    report_mismatch($sformatf("reject_cause %0d, expected %0d",
                                              got_res.reject_cause, exp_res.reject_cause));
                if (got_res.image_width !== exp_res.image_width)
                    report_mismatch($sformatf("image_width %0d, expected %0d",
                                              got_res.image_width, exp_res.image_width));
                if (got_res.image_height !== exp_res.image_height)
                    report_mismatch($sformatf("image_height %0d, expected %0d",
                                              got_res.image_height, exp_res.image_height));
                if (got_res.red !== exp_res.red)
                    report_mismatch($sformatf("red %h, expected %h",
                                              got_res.red, exp_res.red));
                if (got_res.green !== exp_res.green)
                    report_mismatch($sformatf("green %h, expected %h",
                                              got_res.green, exp_res.green));
                if (got_res.blue !== exp_res.blue)
                    report_mismatch($sformatf("blue %h, expected %h",
                                              got_res.blue, exp_res.blue));
                if (got_res.alpha !== exp_res.alpha)
                    report_mismatch($sformatf("alpha %h, expected %h",
                                              got_res.alpha, exp_res.alpha));
                if (got_res.last_pixel !== exp_res.last_pixel)
                    report_mismatch($sformatf("last_pixel %b, expected %b",
                                              got_res.last_pixel, exp_res.last_pixel));
                if (m_tdata[tgad_pkg::OUT_DATA_W-1:66] !== '0)
                    report_mismatch($sformatf("padding bits %h not zero",
                                              m_tdata[tgad_pkg::OUT_DATA_W-1:66]));
                case (exp_res.kind)
                    tgad_pkg::KIND_HEADER: header_results++;
                    tgad_pkg::KIND_PIXEL:  pixel_results++;
                    default:               reject_results++;
                endcase
            end
        end
    end

    // The parser starts in the header phase after reset, so no start flag is needed.
    task automatic test_gray_without_start();
        send_file(1'b0, 8'd0, 8'd0, IMG_GRAY, 16'd2, 16'd2, DEPTH_GRAY,
                  image_bytes(16'd2, 16'd2, DEPTH_GRAY));
    endtask

    task automatic test_truecolor_24();
        send_file(1'b1, 8'd3, 8'd0, IMG_TRUECOLOR, 16'd3, 16'd1, DEPTH_BGR,
                  image_bytes(16'd3, 16'd1, DEPTH_BGR));
        send_file(1'b1, 8'd0, 8'd0, IMG_GRAY, 16'd1, 16'd2, DEPTH_BGR,
                  image_bytes(16'd1, 16'd2, DEPTH_BGR));
    endtask

    // Alternating extreme channel values, then a long image-ID field.
    task automatic test_truecolor_32();
        send_header(1'b1, 8'd0, 8'd0, IMG_TRUECOLOR, 16'd2, 16'd1, DEPTH_BGRA, HEADER_LEN);
        for (int i = 0; i < 8; i++) begin
            send_byte((i % 2 == 0) ^ (i >= 4) ? 8'h00 : 8'hFF, 1'b0);
        end
        send_file(1'b1, 8'd40, 8'd0, IMG_GRAY, 16'd1, 16'd1, DEPTH_BGRA,
                  image_bytes(16'd1, 16'd1, DEPTH_BGRA));
    endtask

    // At least one file per cause; the first one fails all three checks at once.
    task automatic test_reject_causes();
        send_file(1'b1, 8'd0, 8'd1, 8'd1, 16'd2, 16'd2, 8'd16, 4);
        send_file(1'b1, 8'd2, 8'hFF, IMG_GRAY, 16'd1, 16'd1, DEPTH_GRAY, 2);
        send_file(1'b1, 8'd0, 8'd0, 8'd10, 16'd2, 16'd2, 8'd15, 4);
        send_file(1'b1, 8'd0, 8'd0, 8'd0, 16'd1, 16'd1, 8'd0, 1);
        send_file(1'b1, 8'd0, 8'd0, IMG_TRUECOLOR, 16'd2, 16'd2, 8'd16, 4);
    endtask

    // A zero dimension gives the header request alone; later bytes are dropped.
    task automatic test_empty_image();
        send_file(1'b1, 8'd2, 8'd0, IMG_TRUECOLOR, 16'd0, 16'd7, DEPTH_BGR, 6);
        send_file(1'b1, 8'd0, 8'd0, IMG_GRAY, 16'hFFFF, 16'd0, DEPTH_GRAY, 3);
    endtask

    // A start byte must drop the file in progress in every phase.
    task automatic test_restart_mid_file();
        send_file(1'b1, 8'd0, 8'd0, IMG_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_BGRA, 10);
        send_header(1'b1, 8'd1, 8'd0, IMG_GRAY, 16'd3, 16'd3, DEPTH_GRAY, 5);
        send_header(1'b1, 8'd50, 8'd0, IMG_GRAY, 16'd1, 16'd1, DEPTH_GRAY, HEADER_LEN);
        send_random_bytes(5);
        send_header(1'b1, 8'd0, 8'd0, IMG_TRUECOLOR, 16'd2, 16'd2, DEPTH_BGR, HEADER_LEN);
        send_random_bytes(4);
        send_file(1'b1, 8'd0, 8'd0, IMG_TRUECOLOR, 16'd1, 16'd2, DEPTH_BGRA,
                  image_bytes(16'd1, 16'd2, DEPTH_BGRA));
    endtask

    task automatic test_trailing_bytes();
        send_file(1'b1, 8'd0, 8'd0, IMG_GRAY, 16'd2, 16'd1, DEPTH_GRAY, 8);
        send_file(1'b0, 8'd0, 8'd0, IMG_GRAY, 16'd1, 16'd1, DEPTH_GRAY, 1);
    endtask

    // The receiver holds off while the sender streams without gaps, so the
    // decoder fills up and must stall its input; then the sender waits for all results.
    task automatic test_receiver_hold();
        int unsigned saved_send;
        saved_send    = send_idle_pct;
        send_idle_pct = 0;
        hold_request  = 60;
        send_file(1'b1, 8'd0, 8'd0, IMG_TRUECOLOR, 16'd4, 16'd2, DEPTH_BGRA,
                  image_bytes(16'd4, 16'd2, DEPTH_BGRA));
        send_idle_pct = saved_send;
        wait_results_drained();
    endtask

    // Mostly well-formed small files with random content; the rest truncated
    // files, huge dimensions, broken headers and stray bytes.
    task automatic test_random_files(input int unsigned byte_goal);
        int unsigned goal_base;
        int unsigned sel;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  depth;
        logic [7:0]  itype;
        logic [7:0]  map;
        logic [7:0]  id_len;
        logic        st0;
        goal_base = bytes_consumed;
        while (bytes_consumed - goal_base < byte_goal) begin
            sel    = $urandom_range(0, 99);
            w      = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            h      = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            itype  = ($urandom_range(0, 1) == 0) ? IMG_TRUECOLOR : IMG_GRAY;
            id_len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 3));
            st0    = ($urandom_range(0, 19) != 0);
            case ($urandom_range(0, 2))
                0:       depth = DEPTH_GRAY;
                1:       depth = DEPTH_BGR;
                default: depth = DEPTH_BGRA;
            endcase
            if (sel < 72) begin
                send_file(st0, id_len, 8'd0, itype, w, h, depth,
                          image_bytes(w, h, depth) +
                          (($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 4)) : 0));
            end else if (sel < 82) begin
                w = 16'($urandom_range(0, 65535));
                h = 16'($urandom_range(0, 65535));
                send_file(st0, id_len, 8'd0, itype, w, h, depth, $urandom_range(0, 12));
            end else if (sel < 88) begin
                send_header(st0, id_len, 8'd0, itype, w, h, depth, $urandom_range(1, 17));
            end else if (sel < 96) begin
                map   = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
                itype = 8'($urandom_range(0, 255));
                depth = 8'($urandom_range(0, 255));
                send_file(st0, id_len, map, itype, w, h, depth, $urandom_range(0, 6));
            end else begin
                send_random_bytes($urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_gray_without_start();
        test_truecolor_24();
        test_truecolor_32();
        test_reject_causes();
        test_empty_image();
        test_restart_mid_file();
        test_trailing_bytes();
        test_receiver_hold();

        test_random_files(30);
        send_idle_pct = 77;
        recv_idle_pct = 18;
        test_random_files(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_files(50);

        wait_results_drained();
        $display("Sent %0d files (%0d decoded bytes); checked %0d header, %0d pixel",
                 files_sent, bytes_consumed, header_results, pixel_results);
        $display("and %0d reject requests under three idle patterns and one long hold-off.",
                 reject_results);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tgad_pkg.sv
hdl/tgad_in_stage.sv
hdl/tgad_core.sv
hdl/tgad_out_stage.sv
hdl/tga_uncompressed_decoder.sv
tb/tga_uncompressed_decoder_tb.sv
